[rtl/core/query_cosine_similarity_core_defines.svh]
// assertion macros for the cosine similarity core
`ifndef QUERY_COSINE_SIMILARITY_CORE_DEFINES_SVH
`define QUERY_COSINE_SIMILARITY_CORE_DEFINES_SVH

// checked only while out of reset
`define QCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define QCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[rtl/core/qcs_pkg.sv]
// ----------------------------------------------------------------------------
// qcs_pkg
// Shared types and constants of the query cosine similarity core.
// ----------------------------------------------------------------------------
package qcs_pkg;

    localparam int DIM_MAX_DEF = 512;
    localparam int VLEN_W      = 10;
    localparam logic [VLEN_W-1:0] VLEN_RST = 10'd384;
    localparam int ELEM_W      = 16;
    localparam int IDX_W       = 16;
    localparam int QBITS       = 15;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_DOC   = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [ELEM_W-1:0] element;
    } t_in_item;

    typedef struct packed {
        logic signed [ELEM_W-1:0] similarity;
        logic [IDX_W-1:0]         doc_index;
        logic                     zero_norm;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic mul;
        logic acc;
        logic start;
        logic sqrt_step;
        logic mult;
        logic cmp;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic q_full;
        logic is_doc;
        logic doc_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/core/qcs_ram.sv]
// ----------------------------------------------------------------------------
// qcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module qcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/qcs_datapath.sv]
// ----------------------------------------------------------------------------
// qcs_datapath
// Query store, accumulators, square roots, divider and result register.
// ----------------------------------------------------------------------------
module qcs_datapath import qcs_pkg::*; #(
    parameter int DIM_MAX = DIM_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [VLEN_W-1:0]   i_cfg_wr_data,
    input  t_in_item            i_in_data,
    input  logic                i_out_stall,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic                o_out_valid,
    output t_out_item           o_out_data
);

    localparam int CW  = $clog2(DIM_MAX + 1);
    localparam int AW  = DIM_MAX > 1 ? $clog2(DIM_MAX) : 1;
    localparam int LW  = CW > VLEN_W ? CW : VLEN_W;
    localparam int NW  = 31 + $clog2(DIM_MAX);
    localparam int DW  = NW + 1;
    localparam int SW  = (NW + 1) / 2;
    localparam int VW  = (DW > 2 * SW ? DW : 2 * SW) + 1;

    logic [VLEN_W-1:0]        r_vlen;
    logic [CW-1:0]            r_qcnt, r_dcnt;
    logic [NW-1:0]            r_qnorm, r_dnorm;
    logic signed [DW-1:0]     r_dot;
    logic [IDX_W-1:0]         r_doc_cnt, r_res_idx;
    logic signed [ELEM_W-1:0] r_elem;
    logic                     r_mode;
    logic [2*ELEM_W-2:0]      r_sq;
    logic signed [2*ELEM_W-1:0] r_prod;
    logic [2*SW-1:0]          r_qv, r_dv, r_den;
    logic [SW+1:0]            r_qrem, r_drem;
    logic [SW-1:0]            r_qroot, r_droot;
    logic [DW-1:0]            r_mag;
    logic                     r_neg, r_zero, r_sat;
    logic [VW-1:0]            r_rem;
    logic [QBITS-1:0]         r_quo;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [LW-1:0]            vl_ext, eff;
    logic [CW-1:0]            len;
    logic                     q_full, wr_en;
    logic [AW-1:0]            waddr;
    logic [ELEM_W-1:0]        rdata;
    logic [2*SW+1:0]          q_step, d_step;
    logic [VW-1:0]            shifted;
    logic signed [ELEM_W-1:0] sim;
    logic signed [ELEM_W-1:0] qval;
    logic signed [2*ELEM_W-1:0] sq_full;

    function automatic logic [2*SW+1:0] sqrt_step(input logic [SW+1:0] rem,
                                                  input logic [SW-1:0] root,
                                                  input logic [1:0] pair);
        logic [SW+3:0] cand, trial;
        cand  = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (cand >= trial) begin
            sqrt_step = {(SW+2)'(cand - trial), root[SW-2:0], 1'b1};
        end else begin
            sqrt_step = {cand[SW+1:0], root[SW-2:0], 1'b0};
        end
    endfunction

    // effective length: zero acts as one, clamped to the store depth
    always_comb begin
        vl_ext = LW'(r_vlen);
        if (vl_ext == '0) begin
            eff = LW'(1);
        end else if (vl_ext > LW'(DIM_MAX)) begin
            eff = LW'(DIM_MAX);
        end else begin
            eff = vl_ext;
        end
        len = CW'(eff);
    end

    assign q_full = r_qcnt >= len;
    assign wr_en  = i_cmd.take && (i_in_data.mode == MODE_QUERY);
    assign waddr  = q_full ? '0 : r_qcnt[AW-1:0];

    qcs_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DIM_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (i_in_data.element),
        .i_raddr (r_dcnt[AW-1:0]),
        .o_rdata (rdata)
    );

    assign qval    = signed'(rdata);
    assign sq_full = r_elem * r_elem;
    assign q_step  = sqrt_step(r_qrem, r_qroot, r_qv[2*SW-1 -: 2]);
    assign d_step  = sqrt_step(r_drem, r_droot, r_dv[2*SW-1 -: 2]);
    assign shifted = {r_rem[VW-2:0], 1'b0};

    always_comb begin
        if (r_zero) begin
            sim = '0;
        end else if (r_sat) begin
            sim = r_neg ? 16'sh8000 : 16'sh7fff;
        end else if (r_neg) begin
            sim = -signed'({1'b0, r_quo});
        end else begin
            sim = signed'({1'b0, r_quo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen      <= VLEN_RST;
            r_qcnt      <= '0;
            r_dcnt      <= '0;
            r_qnorm     <= '0;
            r_dnorm     <= '0;
            r_dot       <= '0;
            r_doc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vlen    <= i_cfg_wr_data;
                r_qcnt    <= '0;
                r_qnorm   <= '0;
                r_doc_cnt <= '0;
                r_dcnt    <= '0;
                r_dot     <= '0;
                r_dnorm   <= '0;
            end
            // new query after a complete one drops all progress
            if (wr_en && q_full) begin
                r_qcnt    <= '0;
                r_qnorm   <= '0;
                r_doc_cnt <= '0;
                r_dcnt    <= '0;
                r_dot     <= '0;
                r_dnorm   <= '0;
            end
            if (i_cmd.acc) begin
                if (r_mode == MODE_QUERY) begin
                    r_qnorm <= r_qnorm + NW'(r_sq);
                    r_qcnt  <= r_qcnt + CW'(1);
                end else begin
                    r_dot   <= r_dot + DW'(r_prod);
                    r_dnorm <= r_dnorm + NW'(r_sq);
                    r_dcnt  <= r_dcnt + CW'(1);
                end
            end
            if (i_cmd.start) begin
                r_dcnt    <= '0;
                r_dot     <= '0;
                r_dnorm   <= '0;
                r_doc_cnt <= r_doc_cnt + IDX_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_elem <= i_in_data.element;
            r_mode <= i_in_data.mode;
        end
        if (i_cmd.mul) begin
            r_sq   <= sq_full[2*ELEM_W-2:0];
            r_prod <= qval * r_elem;
        end
        if (i_cmd.start) begin
            r_qv      <= (2*SW)'(r_qnorm);
            r_dv      <= (2*SW)'(r_dnorm);
            r_qrem    <= '0;
            r_drem    <= '0;
            r_qroot   <= '0;
            r_droot   <= '0;
            r_neg     <= r_dot < 0;
            r_mag     <= (r_dot < 0) ? DW'(-r_dot) : DW'(r_dot);
            r_zero    <= (r_qnorm == '0) || (r_dnorm == '0);
            r_res_idx <= r_doc_cnt;
        end
        if (i_cmd.sqrt_step) begin
            r_qrem  <= q_step[2*SW+1 -: SW+2];
            r_qroot <= q_step[SW-1:0];
            r_drem  <= d_step[2*SW+1 -: SW+2];
            r_droot <= d_step[SW-1:0];
            r_qv    <= {r_qv[2*SW-3:0], 2'b00};
            r_dv    <= {r_dv[2*SW-3:0], 2'b00};
        end
        if (i_cmd.mult) begin
            r_den <= r_qroot * r_droot;
        end
        // ratio of one or more saturates, else 15 quotient bits remain
        if (i_cmd.cmp) begin
            r_sat <= VW'(r_mag) >= VW'(r_den);
            r_rem <= VW'(r_mag);
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (shifted >= VW'(r_den)) begin
                r_rem <= shifted - VW'(r_den);
                r_quo <= {r_quo[QBITS-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[QBITS-2:0], 1'b0};
            end
        end
        if (i_cmd.load_out) begin
            r_out.similarity <= sim;
            r_out.doc_index  <= r_res_idx;
            r_out.zero_norm  <= r_zero;
        end
    end

    assign o_stat.q_full   = q_full;
    assign o_stat.is_doc   = r_mode == MODE_DOC;
    assign o_stat.doc_last = (r_dcnt + CW'(1)) == len;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

[rtl/core/qcs_ctrl.sv]
// ----------------------------------------------------------------------------
// qcs_ctrl
// Sequencer: element multiply-accumulate, square roots, divide, result load.
// ----------------------------------------------------------------------------
module qcs_ctrl import qcs_pkg::*; #(
    parameter int SQRT_STEPS = 20
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_mode,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    localparam int MAXC = SQRT_STEPS > QBITS ? SQRT_STEPS : QBITS;
    localparam int CTW  = $clog2(MAXC + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_START, S_SQRT, S_MULT, S_DIV, S_DONE
    } t_state;

    t_state         r_state, n_state;
    logic [CTW-1:0] r_cnt, n_cnt;
    logic           take;

    assign take = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = take;
                // document beats before a full query are dropped
                if (take && (i_mode == MODE_QUERY || i_stat.q_full)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = (i_stat.is_doc && i_stat.doc_last) ? S_START : S_IDLE;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_cnt       = CTW'(SQRT_STEPS - 1);
                n_state     = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MULT;
                end else begin
                    n_cnt = r_cnt - CTW'(1);
                end
            end
            S_MULT: begin
                // compare follows the multiply in the next cycle
                o_cmd.mult = 1'b1;
                n_state    = S_DIV;
                n_cnt      = CTW'(QBITS);
            end
            S_DIV: begin
                if (r_cnt == CTW'(QBITS)) begin
                    o_cmd.cmp = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CTW'(1);
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

[rtl/core/query_cosine_similarity_core.sv]
// ----------------------------------------------------------------------------
// query_cosine_similarity_core
// Cosine similarity of streamed document vectors against a stored query.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       input      i_cfg_wr_en               i_cfg_wr_data (vector_length)
//
//  each accepted beat passes through accept, multiply, accumulate
//  the last beat of a document goes on to bit-serial square roots, then a
//  15-step restoring divide
//  document beats before a full query are only accepted and give no result
//  the result register frees the input while a result waits to be taken
//  reset is synchronous; no clearing pass, the query store is written first
module query_cosine_similarity_core import qcs_pkg::*; #(
    parameter int DIM_MAX = DIM_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [VLEN_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

`include "query_cosine_similarity_core_defines.svh"

    localparam int NW         = 31 + $clog2(DIM_MAX);
    localparam int SQRT_STEPS = (NW + 1) / 2;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    qcs_ctrl #(
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    qcs_datapath #(
        .DIM_MAX (DIM_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    `QCS_ASSERT_ALWAYS(a_rst_no_out, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `QCS_ASSERT(a_zero_sim, o_out_valid && o_out_data.zero_norm |-> o_out_data.similarity == 16'sd0, "zero norm with nonzero similarity")
    `QCS_ASSERT(a_query_busy, i_in_valid && !o_in_stall && i_in_data.mode == MODE_QUERY |=> o_in_stall, "query beat not processed")
    `QCS_ASSERT(a_load_free, cmd.load_out |-> stat.out_free, "result overwritten while waiting")

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of query_cosine_similarity_core: a directed table, then random
// query and document vectors over several vector lengths, checked result by
// result against an in-bench model of the similarity datapath.
// ----------------------------------------------------------------------------
module tb;
    import qcs_pkg::*;

    localparam int DIM       = 512;
    localparam int SETTLE    = 60;
    localparam int HOLD_LONG = 400;
    localparam int LIMIT     = 1000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [VLEN_W-1:0] i_cfg_wr_data;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;

    query_cosine_similarity_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // similarity model state
    logic signed [ELEM_W-1:0] q_mem [DIM];
    logic [VLEN_W-1:0]        vlen_reg;
    int unsigned              q_fill;
    longint unsigned          q_energy;
    int unsigned              d_fill;
    longint                   d_dot;
    longint unsigned          d_energy;
    logic [IDX_W-1:0]         d_num;

    t_out_item   sim_expected [$];
    int          errors = 0;
    int          burst_left = 0;
    int          hold_reqs = 0;
    int          hold_done = 0;
    longint      cycles = 0;

    function automatic int unsigned active_len();
        int unsigned n;
        n = vlen_reg;
        if (n == 0) n = 1;
        if (n > DIM) n = DIM;
        return n;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic clear_all();
        q_fill   = 0;
        q_energy = 0;
        d_num    = '0;
        d_fill   = 0;
        d_dot    = 0;
        d_energy = 0;
    endtask

    // advance the model by one accepted beat
    task automatic score_beat(input t_in_item b, output bit has, output t_out_item r);
        longint          e;
        longint unsigned sq;
        longint          sim;
        longint          den;
        has = 1'b0;
        r   = '0;
        e   = b.element;
        sq  = e * e;
        if (b.mode == MODE_QUERY) begin
            if (q_fill >= active_len()) clear_all();
            q_mem[q_fill % DIM] = b.element;
            q_energy += sq;
            q_fill++;
        end else if (q_fill >= active_len()) begin
            d_dot    += longint'(q_mem[d_fill % DIM]) * e;
            d_energy += sq;
            d_fill++;
            if (d_fill >= active_len()) begin
                sim = 0;
                if (q_energy == 0 || d_energy == 0) begin
                    r.zero_norm = 1'b1;
                end else begin
                    den = longint'(root_floor(q_energy) * root_floor(d_energy));
                    sim = (d_dot * 32768) / den;
                    if (sim > 32767) sim = 32767;
                    if (sim < -32768) sim = -32768;
                end
                r.similarity = sim[15:0];
                r.doc_index  = d_num;
                has          = 1'b1;
                d_num++;
                d_fill   = 0;
                d_dot    = 0;
                d_energy = 0;
            end
        end
    endtask

    // offer one beat in bursts with random gaps; returns whether it mattered
    task automatic send_beat(input logic m, input logic signed [ELEM_W-1:0] v,
                             input bit typed, input t_out_item want, output bit used);
        t_in_item  b;
        bit        has;
        t_out_item r;
        int        gap;
        b.mode    = m;
        b.element = v;
        used = !(m == MODE_DOC && q_fill < active_len());
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        score_beat(b, has, r);
        if (has) sim_expected.push_back(typed ? want : r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sim_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [VLEN_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        vlen_reg = v;
        clear_all();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_elem(int style, int unsigned k);
        case (style)
            0: return ELEM_W'($urandom);
            1: return '0;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            3: return q_mem[k % DIM];
            4: return -q_mem[k % DIM];
            default: return $signed(16'($urandom_range(0, 8))) - 16'sd4;
        endcase
    endfunction

    // random vectors at the current length until the budget of beats is used
    task automatic run_phase(input int budget, input bit pause_mid);
        int          count;
        int          n;
        int          style;
        bit          used;
        bit          paused;
        logic        m;
        count  = 0;
        paused = 1'b0;
        while (count < budget) begin
            if (pause_mid && !paused && count > budget / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 24) == 0) begin
                // stray beat
                send_beat(1'($urandom_range(0, 1)), ELEM_W'($urandom), 1'b0, '0, used);
                if (used) count++;
                continue;
            end
            m = (q_fill < active_len() || $urandom_range(0, 11) == 0) ? MODE_QUERY : MODE_DOC;
            style = $urandom_range(0, 9);
            if (m == MODE_QUERY && (style == 3 || style == 4)) style = 0;
            n = active_len();
            if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n);
            for (int k = 0; k < n; k++) begin
                send_beat(m, pick_elem(style > 5 ? 0 : style, k), 1'b0, '0, used);
                if (used) count++;
            end
        end
    endtask

    typedef struct {
        logic                     mode;
        logic signed [ELEM_W-1:0] val;
        bit                       typed;
        t_out_item                want;
    } t_row;

    // vector length 2
    t_row plan [24] = '{
        '{MODE_DOC,   16'sd5,      0, '0},               // ignored, no query yet
        '{MODE_QUERY, 16'sh7fff,   0, '0},
        '{MODE_QUERY, 16'sh7fff,   0, '0},
        '{MODE_DOC,   16'sh7fff,   0, '0},
        '{MODE_DOC,   16'sh7fff,   0, '0},
        '{MODE_DOC,   16'sd0,      0, '0},
        '{MODE_DOC,   16'sd0,      1, '{16'sd0, 16'd1, 1'b1}},
        '{MODE_DOC,   16'sh8000,   0, '0},
        '{MODE_DOC,   16'sh8000,   0, '0},
        '{MODE_QUERY, 16'sd0,      0, '0},               // new query, index restarts
        '{MODE_QUERY, 16'sd0,      0, '0},
        '{MODE_DOC,   16'sd100,    0, '0},
        '{MODE_DOC,   -16'sd100,   1, '{16'sd0, 16'd0, 1'b1}},
        '{MODE_QUERY, 16'sh8000,   0, '0},
        '{MODE_QUERY, 16'sh8000,   0, '0},
        '{MODE_DOC,   16'sh8000,   0, '0},
        '{MODE_DOC,   16'sh8000,   1, '{16'sh7fff, 16'd0, 1'b0}},
        '{MODE_DOC,   16'sh7fff,   0, '0},
        '{MODE_DOC,   16'sh8000,   0, '0},
        '{MODE_QUERY, 16'sd1,      0, '0},
        '{MODE_DOC,   16'sd7,      0, '0},               // query still partial
        '{MODE_QUERY, -16'sd1,     0, '0},
        '{MODE_DOC,   16'sd1,      0, '0},
        '{MODE_DOC,   -16'sd1,     1, '{16'sh7fff, 16'd0, 1'b0}}  // floored roots saturate
    };

    // receiver: own stall pattern, plus a long hold on request
    initial begin
        int pat_left;
        int pct;
        i_out_stall = 1'b0;
        pat_left    = 0;
        pct         = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LONG) @(negedge i_clk);
                hold_done = hold_reqs;
                i_out_stall <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_left = $urandom_range(5, 80);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 30;
                        2: pct = 60;
                        default: pct = 90;
                    endcase
                end
                pat_left--;
                i_out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sim_expected.size() == 0) begin
                $error("result with nothing expected: %p", o_out_data);
                errors++;
            end else begin
                w = sim_expected.pop_front();
                if (o_out_data.similarity !== w.similarity) begin
                    $error("similarity: expected %0d, got %0d", w.similarity,
                           o_out_data.similarity);
                    errors++;
                end
                if (o_out_data.doc_index !== w.doc_index) begin
                    $error("doc_index: expected %0d, got %0d", w.doc_index,
                           o_out_data.doc_index);
                    errors++;
                end
                if (o_out_data.zero_norm !== w.zero_norm) begin
                    $error("zero_norm: expected %0d, got %0d", w.zero_norm,
                           o_out_data.zero_norm);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        bit used;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        vlen_reg      = VLEN_RST;
        clear_all();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset length: a stray document beat must be dropped
        send_beat(MODE_DOC, 16'sd9, 1'b0, '0, used);
        write_len(10'd2);
        foreach (plan[i]) send_beat(plan[i].mode, plan[i].val, plan[i].typed, plan[i].want, used);

        write_len(10'd1);
        run_phase(110, 1'b0);
        write_len(10'd0);
        run_phase(110, 1'b0);
        write_len(10'd3);
        hold_reqs++;
        run_phase(140, 1'b0);
        write_len(10'd1023);
        run_phase(1024, 1'b0);
        write_len(10'd5);
        run_phase(140, 1'b1);
        write_len(10'd8);
        run_phase(140, 1'b0);
        write_len(10'd2);
        run_phase(100, 1'b0);

        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
